// File: src/brs_pkg.sv
// Package: shared constants, codes and state types for the rectangle segmentation block.
`timescale 1ns / 1ps
package brs_pkg;

    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int CFG_W          = 7;
    localparam int PIX_W          = 9;
    localparam int PIX_MAX        = 256;
    localparam int FRAC_SHIFT     = 8;
    localparam int ROW_OUT_W      = 6;
    localparam int END_OUT_W      = 7;
    localparam int COLOR_W        = 17;
    localparam int DEF_SIZE       = 64;

    localparam logic CFG_HEIGHT = 1'b0;
    localparam logic CFG_WIDTH  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RD,
        ST_AFTER,
        ST_HW,
        ST_SQA,
        ST_DIVA,
        ST_SQB,
        ST_DIVB,
        ST_CMP,
        ST_MEAN_I,
        ST_DIV_I,
        ST_MEAN_O,
        ST_DIV_O,
        ST_OUT
    } brs_state_t;

    typedef enum logic [1:0] {
        PH_TOTAL,
        PH_CAND,
        PH_FINAL
    } brs_phase_t;

endpackage

// File: src/best_rectangle_segmentation_top.sv
// Top level: summed-area table build and best-rectangle search sequencer.
//
// Pixels of one image enter in raster order on in_valid/in_stall with
// pixel_value; a transfer happens when in_valid is high and in_stall low.
// Each pixel takes one table read of the row above, then one write.
// After the last pixel the block runs the search and keeps in_stall high.
// Every candidate rectangle takes 4 table reads plus two quotients from the
// shared divider, one quotient bit per cycle, and there are about
// (H*(H+1)/2)*(W*(W+1)/2) candidates. The final means take two more divisions,
// the second skipped when the outer area is empty.
// The result appears on out_valid with the corners and mean colors and holds
// while out_stall is high; the next pixel is taken after that transfer.
// Configuration writes (cfg_write_en, cfg_index, cfg_data) set the image
// size and restart the image; issue them only while idle.
// Reset (rst_n, asynchronous, active low) sets the size to 64 by 64 and
// empties the block. The table needs no clearing pass: its zero border is
// never stored and reads back as zero.
`timescale 1ns / 1ps
module best_rectangle_segmentation_top #(
    parameter int MAX_HEIGHT = brs_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = brs_pkg::DEF_MAX_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic                         cfg_index,
    input  logic [brs_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [brs_pkg::PIX_W-1:0]    pixel_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [brs_pkg::ROW_OUT_W-1:0] top_row,
    output logic [brs_pkg::ROW_OUT_W-1:0] left_col,
    output logic [brs_pkg::END_OUT_W-1:0] bottom_row,
    output logic [brs_pkg::END_OUT_W-1:0] right_col,
    output logic [brs_pkg::COLOR_W-1:0]  outer_color,
    output logic [brs_pkg::COLOR_W-1:0]  inner_color
);

    localparam int MAXD   = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
    localparam int CW     = $clog2(MAXD + 2);
    localparam int LW     = (CW > brs_pkg::CFG_W) ? CW : brs_pkg::CFG_W;
    localparam int AW     = $clog2(MAX_HEIGHT * MAX_WIDTH + 1);
    localparam int SW     = $clog2(brs_pkg::PIX_MAX * MAX_HEIGHT * MAX_WIDTH + 1);
    localparam int RSW    = $clog2(brs_pkg::PIX_MAX * MAX_WIDTH + 1);
    localparam int QW     = 2 * SW;
    localparam int DEPTH  = (MAX_HEIGHT + 1) * (MAX_WIDTH + 1);
    localparam int ADW    = $clog2(DEPTH);
    localparam int STRIDE = MAX_WIDTH + 1;
    localparam int RST_H  = (brs_pkg::DEF_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : brs_pkg::DEF_SIZE;
    localparam int RST_W  = (brs_pkg::DEF_SIZE > MAX_WIDTH) ? MAX_WIDTH : brs_pkg::DEF_SIZE;

    brs_pkg::brs_state_t state_reg, state_next;
    brs_pkg::brs_phase_t phase_reg;

    logic [CW-1:0]  img_h_reg, img_w_reg;
    logic [CW-1:0]  row_reg, col_reg;
    logic [RSW-1:0] rs_reg;
    logic [CW-1:0]  h_reg, w_reg, r_reg, c_reg;
    logic [CW-1:0]  b_r0_reg, b_c0_reg, b_r1_reg, b_c1_reg;
    logic           found_reg;
    logic [QW:0]    best_reg;
    logic [2:0]     cnt_reg;
    logic [SW:0]    acc_reg;
    logic [SW-1:0]  t_reg;
    logic [AW-1:0]  p_reg, x_reg, y_reg;
    logic [QW-1:0]  qa_reg;
    logic [brs_pkg::COLOR_W-1:0] inner_reg, outer_reg;
    logic           zero_reg;

    logic           accept_in;
    logic [LW-1:0]  cfg_ext;
    logic [CW-1:0]  cfg_size_h, cfg_size_w;
    logic [brs_pkg::PIX_W-1:0] pix_sat;
    logic [RSW-1:0] rs_new;
    logic           last_pix;

    logic [CW-1:0]  cr0, cc0, cr1, cc1, sel_r, sel_c;
    logic [ADW-1:0] rd_addr, wr_addr, ld_addr;
    logic           mem_re, mem_we;
    logic [SW-1:0]  mem_rdata, mem_wdata, rd_val;
    logic [SW-1:0]  vx, rest;

    logic [SW-1:0]  mul_a, mul_b;
    logic [QW-1:0]  mul_p;

    logic           div_start, div_done;
    logic [QW-1:0]  div_num, div_quo;
    logic [AW-1:0]  div_den;
    logic [QW:0]    score;

    logic           rd_done, hw_over, hw_skip, c_end, r_end, w_last;
    logic [CW-1:0]  h_adv, w_adv;

    assign accept_in = in_valid && !in_stall;
    assign cfg_ext   = LW'(cfg_data);
    assign pix_sat   = (pixel_value > brs_pkg::PIX_W'(brs_pkg::PIX_MAX))
                       ? brs_pkg::PIX_W'(brs_pkg::PIX_MAX) : pixel_value;
    assign rs_new    = ((col_reg == '0) ? RSW'(0) : rs_reg) + RSW'(pix_sat);
    assign last_pix  = (row_reg == img_h_reg - CW'(1)) && (col_reg == img_w_reg - CW'(1));

    always_comb
    begin
        priority if (cfg_ext == '0)
            cfg_size_h = CW'(1);
        else if (cfg_ext > LW'(MAX_HEIGHT))
            cfg_size_h = CW'(MAX_HEIGHT);
        else
            cfg_size_h = CW'(cfg_ext);
        priority if (cfg_ext == '0)
            cfg_size_w = CW'(1);
        else if (cfg_ext > LW'(MAX_WIDTH))
            cfg_size_w = CW'(MAX_WIDTH);
        else
            cfg_size_w = CW'(cfg_ext);
    end

    // corner coordinates of the rectangle being summed
    always_comb
    begin
        unique case (phase_reg)
            brs_pkg::PH_TOTAL:
            begin
                cr0 = '0;
                cc0 = '0;
                cr1 = img_h_reg;
                cc1 = img_w_reg;
            end
            brs_pkg::PH_CAND:
            begin
                cr0 = r_reg;
                cc0 = c_reg;
                cr1 = r_reg + h_reg;
                cc1 = c_reg + w_reg;
            end
            default:
            begin
                cr0 = b_r0_reg;
                cc0 = b_c0_reg;
                cr1 = b_r1_reg;
                cc1 = b_c1_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:
            begin
                sel_r = cr1;
                sel_c = cc1;
            end
            2'd1:
            begin
                sel_r = cr0;
                sel_c = cc0;
            end
            2'd2:
            begin
                sel_r = cr0;
                sel_c = cc1;
            end
            default:
            begin
                sel_r = cr1;
                sel_c = cc0;
            end
        endcase
    end

    assign ld_addr = ADW'(row_reg) * ADW'(STRIDE) + ADW'(col_reg + CW'(1));
    assign wr_addr = ADW'(row_reg + CW'(1)) * ADW'(STRIDE) + ADW'(col_reg + CW'(1));
    assign rd_addr = (state_reg == brs_pkg::ST_IDLE) ? ld_addr
                     : ADW'(sel_r) * ADW'(STRIDE) + ADW'(sel_c);

    assign rd_val    = zero_reg ? '0 : mem_rdata;
    assign mem_wdata = rd_val + SW'(rs_reg);
    assign vx        = acc_reg[SW-1:0];
    assign rest      = t_reg - vx;

    // shared multiplier
    always_comb
    begin
        mul_a = vx;
        mul_b = vx;
        unique case (state_reg)
            brs_pkg::ST_HW:
            begin
                mul_a = SW'(h_reg);
                mul_b = SW'(w_reg);
            end
            brs_pkg::ST_AFTER:
            begin
                if (phase_reg == brs_pkg::PH_TOTAL)
                begin
                    mul_a = SW'(img_h_reg);
                    mul_b = SW'(img_w_reg);
                end
                else
                begin
                    mul_a = SW'(b_r1_reg - b_r0_reg);
                    mul_b = SW'(b_c1_reg - b_c0_reg);
                end
            end
            brs_pkg::ST_SQB:
            begin
                mul_a = rest;
                mul_b = rest;
            end
            default:
            begin
                mul_a = vx;
                mul_b = vx;
            end
        endcase
    end

    assign mul_p = QW'(mul_a) * QW'(mul_b);

    assign div_num = (state_reg == brs_pkg::ST_MEAN_I) ? (QW'(vx) << brs_pkg::FRAC_SHIFT)
                   : (state_reg == brs_pkg::ST_MEAN_O) ? (QW'(rest) << brs_pkg::FRAC_SHIFT)
                   : mul_p;
    assign div_den = ((state_reg == brs_pkg::ST_SQA) || (state_reg == brs_pkg::ST_MEAN_I))
                     ? x_reg : y_reg;
    assign score   = (QW + 1)'(qa_reg) + (QW + 1)'(div_quo);

    assign rd_done = (cnt_reg == 3'd4);
    assign hw_over = (h_reg > img_h_reg);
    assign hw_skip = (h_reg == img_h_reg) && (w_reg == img_w_reg);
    assign w_last  = (w_reg == img_w_reg);
    assign h_adv   = w_last ? h_reg + CW'(1) : h_reg;
    assign w_adv   = w_last ? CW'(1) : w_reg + CW'(1);
    assign c_end   = (c_reg + w_reg == img_w_reg);
    assign r_end   = (r_reg + h_reg == img_h_reg);

    brs_mem #(
        .DEPTH (DEPTH),
        .AW    (ADW),
        .DW    (SW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_addr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    brs_div #(
        .NW (QW),
        .DW (AW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brs_pkg::ST_IDLE:
                if (accept_in)
                    state_next = brs_pkg::ST_LOAD;
            brs_pkg::ST_LOAD:
                state_next = last_pix ? brs_pkg::ST_RD : brs_pkg::ST_IDLE;
            brs_pkg::ST_RD:
                if (rd_done)
                    state_next = brs_pkg::ST_AFTER;
            brs_pkg::ST_AFTER:
            begin
                unique case (phase_reg)
                    brs_pkg::PH_TOTAL: state_next = brs_pkg::ST_HW;
                    brs_pkg::PH_CAND:  state_next = brs_pkg::ST_SQA;
                    default:           state_next = brs_pkg::ST_MEAN_I;
                endcase
            end
            brs_pkg::ST_HW:
            begin
                priority if (hw_over)
                    state_next = brs_pkg::ST_RD;
                else if (hw_skip)
                    state_next = brs_pkg::ST_HW;
                else
                    state_next = brs_pkg::ST_RD;
            end
            brs_pkg::ST_SQA:
                state_next = brs_pkg::ST_DIVA;
            brs_pkg::ST_DIVA:
                if (div_done)
                    state_next = brs_pkg::ST_SQB;
            brs_pkg::ST_SQB:
                state_next = brs_pkg::ST_DIVB;
            brs_pkg::ST_DIVB:
                if (div_done)
                    state_next = brs_pkg::ST_CMP;
            brs_pkg::ST_CMP:
                state_next = (c_end && r_end) ? brs_pkg::ST_HW : brs_pkg::ST_RD;
            brs_pkg::ST_MEAN_I:
                state_next = brs_pkg::ST_DIV_I;
            brs_pkg::ST_DIV_I:
                if (div_done)
                    state_next = brs_pkg::ST_MEAN_O;
            brs_pkg::ST_MEAN_O:
                state_next = (y_reg == '0) ? brs_pkg::ST_OUT : brs_pkg::ST_DIV_O;
            brs_pkg::ST_DIV_O:
                if (div_done)
                    state_next = brs_pkg::ST_OUT;
            brs_pkg::ST_OUT:
                if (!out_stall)
                    state_next = brs_pkg::ST_IDLE;
            default:
                state_next = brs_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall  = (state_reg != brs_pkg::ST_IDLE);
        out_valid = (state_reg == brs_pkg::ST_OUT);
        mem_we    = (state_reg == brs_pkg::ST_LOAD);
        mem_re    = ((state_reg == brs_pkg::ST_IDLE) && accept_in)
                    || ((state_reg == brs_pkg::ST_RD) && !cnt_reg[2]);
        div_start = (state_reg == brs_pkg::ST_SQA) || (state_reg == brs_pkg::ST_SQB)
                    || (state_reg == brs_pkg::ST_MEAN_I)
                    || ((state_reg == brs_pkg::ST_MEAN_O) && (y_reg != '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brs_pkg::ST_IDLE;
            phase_reg <= brs_pkg::PH_TOTAL;
            img_h_reg <= CW'(RST_H);
            img_w_reg <= CW'(RST_W);
            row_reg   <= '0;
            col_reg   <= '0;
            rs_reg    <= '0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                if (cfg_index == brs_pkg::CFG_HEIGHT)
                    img_h_reg <= cfg_size_h;
                else
                    img_w_reg <= cfg_size_w;
                row_reg <= '0;
                col_reg <= '0;
                rs_reg  <= '0;
            end
            unique case (state_reg)
                brs_pkg::ST_IDLE:
                    if (accept_in)
                        rs_reg <= rs_new;
                brs_pkg::ST_LOAD:
                begin
                    if (last_pix)
                    begin
                        row_reg   <= '0;
                        col_reg   <= '0;
                        phase_reg <= brs_pkg::PH_TOTAL;
                        cnt_reg   <= '0;
                    end
                    else if (col_reg == img_w_reg - CW'(1))
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + CW'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + CW'(1);
                    end
                end
                brs_pkg::ST_RD:
                    if (!rd_done)
                        cnt_reg <= cnt_reg + 3'd1;
                brs_pkg::ST_AFTER:
                    if (phase_reg == brs_pkg::PH_TOTAL)
                    begin
                        phase_reg <= brs_pkg::PH_CAND;
                        found_reg <= 1'b0;
                    end
                brs_pkg::ST_HW:
                begin
                    cnt_reg <= '0;
                    if (hw_over)
                        phase_reg <= brs_pkg::PH_FINAL;
                end
                brs_pkg::ST_CMP:
                begin
                    cnt_reg <= '0;
                    if (!found_reg || (score > best_reg))
                        found_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            zero_reg <= (state_reg == brs_pkg::ST_IDLE) ? (row_reg == '0)
                        : ((sel_r == '0) || (sel_c == '0));
        unique case (state_reg)
            brs_pkg::ST_LOAD:
                acc_reg <= '0;
            brs_pkg::ST_RD:
                if (cnt_reg != 3'd0)
                begin
                    if ((cnt_reg == 3'd3) || (cnt_reg == 3'd4))
                        acc_reg <= acc_reg - (SW + 1)'(rd_val);
                    else
                        acc_reg <= acc_reg + (SW + 1)'(rd_val);
                end
            brs_pkg::ST_AFTER:
            begin
                if (phase_reg == brs_pkg::PH_TOTAL)
                begin
                    t_reg    <= vx;
                    p_reg    <= AW'(mul_p);
                    h_reg    <= CW'(1);
                    w_reg    <= CW'(1);
                    b_r0_reg <= '0;
                    b_c0_reg <= '0;
                    b_r1_reg <= CW'(1);
                    b_c1_reg <= CW'(1);
                end
                else if (phase_reg == brs_pkg::PH_FINAL)
                begin
                    x_reg <= AW'(mul_p);
                    y_reg <= p_reg - AW'(mul_p);
                end
            end
            brs_pkg::ST_HW:
            begin
                acc_reg <= '0;
                if (!hw_over && hw_skip)
                begin
                    h_reg <= h_adv;
                    w_reg <= w_adv;
                end
                else if (!hw_over)
                begin
                    x_reg <= AW'(mul_p);
                    y_reg <= p_reg - AW'(mul_p);
                    r_reg <= '0;
                    c_reg <= '0;
                end
            end
            brs_pkg::ST_DIVA:
                if (div_done)
                    qa_reg <= div_quo;
            brs_pkg::ST_CMP:
            begin
                acc_reg <= '0;
                if (!found_reg || (score > best_reg))
                begin
                    best_reg <= score;
                    b_r0_reg <= r_reg;
                    b_c0_reg <= c_reg;
                    b_r1_reg <= r_reg + h_reg;
                    b_c1_reg <= c_reg + w_reg;
                end
                if (!c_end)
                    c_reg <= c_reg + CW'(1);
                else
                begin
                    c_reg <= '0;
                    if (!r_end)
                        r_reg <= r_reg + CW'(1);
                    else
                    begin
                        h_reg <= h_adv;
                        w_reg <= w_adv;
                    end
                end
            end
            brs_pkg::ST_DIV_I:
                if (div_done)
                    inner_reg <= brs_pkg::COLOR_W'(div_quo);
            brs_pkg::ST_MEAN_O:
                if (y_reg == '0)
                    outer_reg <= '0;
            brs_pkg::ST_DIV_O:
                if (div_done)
                    outer_reg <= brs_pkg::COLOR_W'(div_quo);
            default:
            begin
            end
        endcase
    end

    assign top_row     = brs_pkg::ROW_OUT_W'(b_r0_reg);
    assign left_col    = brs_pkg::ROW_OUT_W'(b_c0_reg);
    assign bottom_row  = brs_pkg::END_OUT_W'(b_r1_reg);
    assign right_col   = brs_pkg::END_OUT_W'(b_c1_reg);
    assign outer_color = outer_reg;
    assign inner_color = inner_reg;

    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("pixel taken while a result waits");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == brs_pkg::ST_DIVA || state_reg == brs_pkg::ST_DIVB
                      || state_reg == brs_pkg::ST_DIV_I || state_reg == brs_pkg::ST_DIV_O))
        else $error("divider finished outside a wait state");

    a_idle_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !in_stall && !out_valid)
        else $error("block not idle after result transfer");

    a_load_is_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brs_pkg::ST_LOAD) |=> !out_valid)
        else $error("result shown right after a table write");

endmodule

// File: src/brs_mem.sv
// Summed-area table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module brs_mem #(
    parameter int DEPTH = 4225,
    parameter int AW    = 13,
    parameter int DW    = 21
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/brs_div.sv
// Shared iterative divider: restoring division, one quotient bit per cycle.
`timescale 1ns / 1ps
module brs_div #(
    parameter int NW = 42,
    parameter int DW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CNW = $clog2(NW + 1);

    logic           busy_reg;
    logic [CNW-1:0] cnt_reg;
    logic           done_reg;
    logic [NW-1:0]  dvd_reg;
    logic [DW-1:0]  rem_reg;
    logic [NW-1:0]  quo_reg;
    logic [DW-1:0]  den_reg;
    logic [DW:0]    rem_sh;
    logic           ge;

    assign rem_sh   = {rem_reg, dvd_reg[NW-1]};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNW'(1);
                if (cnt_reg == CNW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= ge ? DW'(rem_sh - {1'b0, den_reg}) : DW'(rem_sh);
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

endmodule

// File: bench/best_rectangle_segmentation_top_tb.sv
// Testbench: drives whole images, predicts each best rectangle and its means, checks the result.
`timescale 1ns / 1ps
module best_rectangle_segmentation_top_tb;

    typedef struct packed {
        logic [brs_pkg::ROW_OUT_W-1:0] top;
        logic [brs_pkg::ROW_OUT_W-1:0] left;
        logic [brs_pkg::END_OUT_W-1:0] bottom;
        logic [brs_pkg::END_OUT_W-1:0] right;
        logic [brs_pkg::COLOR_W-1:0]   outer;
        logic [brs_pkg::COLOR_W-1:0]   inner;
    } rect_t;

    class rect_scoreboard;
        int unsigned height = brs_pkg::DEF_SIZE;
        int unsigned width = brs_pkg::DEF_SIZE;
        int unsigned sat[(brs_pkg::DEF_MAX_HEIGHT+1)*(brs_pkg::DEF_MAX_WIDTH+1)];
        int unsigned count;
        int unsigned row_acc;
        rect_t rect_q[$];
        int errors;
        int matched;

        function new();
            foreach (sat[i]) sat[i] = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        function void set_size(logic idx, int unsigned v);
            int unsigned s;
            s = (v == 0) ? 1 : ((v > 64) ? 64 : v);
            if (idx == brs_pkg::CFG_HEIGHT) height = s;
            else width = s;
            count = 0;
            row_acc = 0;
        endfunction

        function longint area_sum(int r0, int c0, int r1, int c1);
            return longint'(sat[r1*65+c1]) + sat[r0*65+c0] - sat[r0*65+c1] - sat[r1*65+c0];
        endfunction

        function rect_t best_rectangle();
            longint total, px, score, best, vx, rest, a, b, inner, outer;
            int br0, bc0, br1, bc1;
            rect_t res;
            px = height * width;
            total = sat[height*65+width];
            best = -1;
            br0 = 0; bc0 = 0; br1 = 1; bc1 = 1;
            for (int h = 1; h <= height; h++)
                for (int w = 1; w <= width; w++) begin
                    if (h == height && w == width) continue;
                    a = h * w;
                    b = px - a;
                    for (int r = 0; r + h <= height; r++)
                        for (int c = 0; c + w <= width; c++) begin
                            vx = area_sum(r, c, r + h, c + w);
                            rest = total - vx;
                            score = (vx * vx) / a + (rest * rest) / b;
                            if (score > best) begin
                                best = score;
                                br0 = r; bc0 = c; br1 = r + h; bc1 = c + w;
                            end
                        end
                end
            vx = area_sum(br0, bc0, br1, bc1);
            a = (br1 - br0) * (bc1 - bc0);
            b = px - a;
            inner = (a != 0) ? (vx * 256) / a : 0;
            outer = (b != 0) ? ((total - vx) * 256) / b : 0;
            res.top = brs_pkg::ROW_OUT_W'(br0);
            res.left = brs_pkg::ROW_OUT_W'(bc0);
            res.bottom = brs_pkg::END_OUT_W'(br1);
            res.right = brs_pkg::END_OUT_W'(bc1);
            res.outer = brs_pkg::COLOR_W'(outer);
            res.inner = brs_pkg::COLOR_W'(inner);
            return res;
        endfunction

        function void note_pixel(int unsigned v);
            int unsigned p, r, c;
            p = (v > brs_pkg::PIX_MAX) ? brs_pkg::PIX_MAX : v;
            r = count / width;
            c = count % width;
            if (r >= height) begin
                r = 0; c = 0; count = 0;
            end
            if (c == 0) row_acc = 0;
            row_acc += p;
            sat[(r+1)*65+c+1] = sat[r*65+c+1] + row_acc;
            count++;
            if (count == height * width) begin
                count = 0;
                row_acc = 0;
                rect_q.push_back(best_rectangle());
            end
        endfunction

        task check_result(rect_t got);
            rect_t want;
            if (rect_q.size() == 0) begin
                report("result with no image pending");
                return;
            end
            want = rect_q.pop_front();
            if (got.top != want.top) report($sformatf("top_row %0d exp %0d", got.top, want.top));
            if (got.left != want.left)
                report($sformatf("left_col %0d exp %0d", got.left, want.left));
            if (got.bottom != want.bottom)
                report($sformatf("bottom_row %0d exp %0d", got.bottom, want.bottom));
            if (got.right != want.right)
                report($sformatf("right_col %0d exp %0d", got.right, want.right));
            if (got.outer != want.outer)
                report($sformatf("outer_color %0d exp %0d", got.outer, want.outer));
            if (got.inner != want.inner)
                report($sformatf("inner_color %0d exp %0d", got.inner, want.inner));
            matched++;
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_write_en = 0;
    logic cfg_index = 0;
    logic [brs_pkg::CFG_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic [brs_pkg::PIX_W-1:0] pixel_value = '0;
    logic out_valid;
    logic out_stall = 0;
    logic [brs_pkg::ROW_OUT_W-1:0] top_row, left_col;
    logic [brs_pkg::END_OUT_W-1:0] bottom_row, right_col;
    logic [brs_pkg::COLOR_W-1:0] outer_color, inner_color;

    rect_scoreboard sb = new();
    bit steady;
    bit long_hold;
    int pixels_sent;
    int images_sent;

    best_rectangle_segmentation_top dut (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{top_row, left_col, bottom_row, right_col, outer_color, inner_color});

    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            n = steady ? 0 : $urandom_range(0, 6);
            if (long_hold) begin
                n = 400;
                long_hold = 0;
            end
            if (n > 0) begin
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task write_size(logic idx, int unsigned v);
        in_valid <= 0;
        while (sb.rect_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_write_en <= 1;
        cfg_index <= idx;
        cfg_data <= brs_pkg::CFG_W'(v);
        @(posedge clk);
        cfg_write_en <= 0;
        sb.set_size(idx, v);
    endtask

    task send_pixel(int unsigned v);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        pixel_value <= brs_pkg::PIX_W'(v);
        do @(posedge clk); while (in_stall);
        sb.note_pixel(v);
        pixels_sent++;
    endtask

    function int unsigned rand_pixel();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 511);
        return $urandom_range(0, 256);
    endfunction

    task send_image(int unsigned npix);
        for (int i = 0; i < npix; i++) send_pixel(rand_pixel());
        images_sent++;
    endtask

    initial begin
        int h, w, imgs;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        write_size(brs_pkg::CFG_HEIGHT, 1);
        write_size(brs_pkg::CFG_WIDTH, 1);
        send_pixel(0);
        send_pixel(brs_pkg::PIX_MAX);
        send_pixel(511);
        send_pixel(300);
        images_sent += 4;
        write_size(brs_pkg::CFG_HEIGHT, 2);
        write_size(brs_pkg::CFG_WIDTH, 2);
        repeat (4) send_pixel(100);
        send_pixel(0); send_pixel(0); send_pixel(0); send_pixel(brs_pkg::PIX_MAX);
        images_sent += 2;
        write_size(brs_pkg::CFG_WIDTH, 3);
        repeat (6) send_pixel(brs_pkg::PIX_MAX);
        images_sent++;

        long_hold = 1;
        while (pixels_sent < 780) begin
            h = $urandom_range(1, 5);
            w = $urandom_range(1, 5);
            write_size(brs_pkg::CFG_HEIGHT, h);
            write_size(brs_pkg::CFG_WIDTH, w);
            steady = ($urandom_range(0, 3) == 0);
            imgs = $urandom_range(2, 5);
            repeat (imgs) send_image(h * w);
        end
        steady = 0;

        write_size(brs_pkg::CFG_HEIGHT, 0);
        write_size(brs_pkg::CFG_WIDTH, 127);
        send_image(64);
        write_size(brs_pkg::CFG_HEIGHT, 127);
        write_size(brs_pkg::CFG_WIDTH, 1);
        send_image(64);
        write_size(brs_pkg::CFG_HEIGHT, 2);
        write_size(brs_pkg::CFG_WIDTH, 0);
        send_image(2);
        in_valid <= 0;

        while (sb.rect_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Covered %0d images (%0d pixels), %0d results checked, sizes 1x1 to 64x1.",
                 images_sent, pixels_sent, sb.matched);
        if (sb.errors == 0)
            $display("** best_rectangle_segmentation_top: PASSED **");
        else
            $display("** best_rectangle_segmentation_top: FAILED **");
        $finish;
    end

    initial begin
        #40ms;
        $display("Timeout with %0d results outstanding", sb.rect_q.size());
        $display("** best_rectangle_segmentation_top: FAILED **");
        $finish;
    end
endmodule

// File: best_rectangle_segmentation_top.f
src/brs_pkg.sv
src/brs_mem.sv
src/brs_div.sv
src/best_rectangle_segmentation_top.sv
bench/best_rectangle_segmentation_top_tb.sv
